### rtl/lmsd_pkg.sv
// Package with shared types, constants and codes for the LED matrix scan driver.
`timescale 1ns / 1ps

package lmsd_pkg;

  localparam int DEF_ROW_PIXELS = 64;
  localparam int DEF_ROWS       = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] COLOR_MAX = 3'b111;
  localparam logic [3:0] ADDR_MAX  = 4'hF;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_FILL,
    CMD_REFRESH
  } cmd_op_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_REFRESH
  } back_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel_color;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [2:0] upper_shade;
    logic [2:0] lower_shade;
    logic       latch_now;
  } out_item_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] color;
    logic [7:0] col;
    logic [4:0] row;
  } cmd_t;

endpackage

### rtl/lmsd_in_if.sv
// Input channel interface carrying command items.
`timescale 1ns / 1ps

interface lmsd_in_if;
  logic               valid;
  logic               ready;
  lmsd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/lmsd_out_if.sv
// Output channel interface carrying shift items.
`timescale 1ns / 1ps

interface lmsd_out_if;
  logic                valid;
  logic                ready;
  lmsd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/led_matrix_scan_driver.sv
// Top level of the LED matrix scan driver: front end, command queue and back end.
//
//   channel   direction  contents
//   in_ch     sink       opcode, pixel_color, pixel_column, pixel_row
//   out_ch    source     row_address, upper_shade, lower_shade, latch_now
//
// A write is done in the back end in the same cycle it is taken from the queue, and a
// fill writes one pixel per cycle through the single frame buffer write port after
// the command is taken. A refresh gives ROW_PIXELS items, one per cycle while out_ch
// is ready, read through the two frame buffer read ports into the s1 stage and then
// registered onto out_ch. After reset a clearing pass over all ROWS*ROW_PIXELS pixels
// (2048 by default) runs, and in_ch.ready stays low until it ends. The queue holds
// four commands, so items keep being accepted until it fills while the back end
// is busy or out_ch is stalled.
`timescale 1ns / 1ps

module led_matrix_scan_driver #(
  parameter int ROW_PIXELS = lmsd_pkg::DEF_ROW_PIXELS,
  parameter int ROWS       = lmsd_pkg::DEF_ROWS
) (
  input logic        clk,
  input logic        rst,
  lmsd_in_if.sink    in_ch,
  lmsd_out_if.source out_ch
);
  import lmsd_pkg::*;

  logic init_done;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  lmsd_front #(
    .ROW_PIXELS(ROW_PIXELS),
    .ROWS      (ROWS)
  ) u_front (
    .in_ch    (in_ch),
    .init_done(init_done),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  lmsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  lmsd_back #(
    .ROW_PIXELS(ROW_PIXELS),
    .ROWS      (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .init_done(init_done),
    .out_ch   (out_ch)
  );

endmodule

### rtl/lmsd_front.sv
// Front end: accepts command items, saturates and redirects them, drops unknown opcodes, and queues the rest.
`timescale 1ns / 1ps

module lmsd_front #(
  parameter int ROW_PIXELS = lmsd_pkg::DEF_ROW_PIXELS,
  parameter int ROWS       = lmsd_pkg::DEF_ROWS
) (
  lmsd_in_if.sink        in_ch,
  input  logic           init_done,
  input  logic           q_full,
  output logic           push,
  output lmsd_pkg::cmd_t cmd
);
  import lmsd_pkg::*;

  logic known_op;

  assign in_ch.ready = init_done && !q_full;

  always_comb begin
    known_op = 1'b1;
    cmd.op   = CMD_WRITE;
    case (in_ch.payload.opcode)
      OP_WRITE:   cmd.op = CMD_WRITE;
      OP_FILL:    cmd.op = CMD_FILL;
      OP_REFRESH: cmd.op = CMD_REFRESH;
      default:    known_op = 1'b0;
    endcase
    if (in_ch.payload.pixel_color > 8'(COLOR_MAX)) begin
      cmd.color = COLOR_MAX;
    end else begin
      cmd.color = in_ch.payload.pixel_color[2:0];
    end
    if ({1'b0, in_ch.payload.pixel_column} >= 9'(ROW_PIXELS)) begin
      cmd.col = '0;
    end else begin
      cmd.col = in_ch.payload.pixel_column;
    end
    if ({1'b0, in_ch.payload.pixel_row} >= 9'(ROWS)) begin
      cmd.row = '0;
    end else begin
      cmd.row = in_ch.payload.pixel_row[4:0];
    end
  end

  assign push = in_ch.valid && in_ch.ready && known_op;

endmodule

### rtl/lmsd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module lmsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lmsd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lmsd_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import lmsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW + 1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/lmsd_back.sv
// Back end: frame buffer, clear and fill sweeps, and the refresh shift pipeline.
`timescale 1ns / 1ps

module lmsd_back #(
  parameter int ROW_PIXELS = lmsd_pkg::DEF_ROW_PIXELS,
  parameter int ROWS       = lmsd_pkg::DEF_ROWS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  lmsd_pkg::cmd_t head,
  output logic           pop,
  output logic           init_done,
  lmsd_out_if.source     out_ch
);
  import lmsd_pkg::*;

  localparam int CW   = (ROW_PIXELS > 1) ? $clog2(ROW_PIXELS) : 1;
  localparam int RW   = $clog2(ROWS);
  localparam int AW   = RW + CW;
  localparam int HALF = ROWS / 2;
  localparam logic [CW-1:0] LAST_COL = CW'(ROW_PIXELS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  logic [2:0] mem [0:(1 << AW) - 1];

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [2:0]    fill_color;
  logic [4:0]    scan_row;
  logic [4:0]    pair;
  logic [4:0]    pair_start;
  logic [5:0]    hi_row_full;

  logic          s1_valid;
  logic          s1_latch;
  logic [3:0]    s1_addr;
  logic [2:0]    lo_data;
  logic [2:0]    hi_data;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [2:0]    mem_wdata;
  logic [AW-1:0] lo_addr;
  logic [AW-1:0] hi_addr;
  logic          last_col;
  logic          last_row;
  logic          o_load;
  logic          s1_free;
  logic          issue;

  assign last_col    = (col_cnt == LAST_COL);
  assign last_row    = (row_cnt == LAST_ROW);
  assign o_load      = s1_valid && (!out_ch.valid || out_ch.ready);
  assign s1_free     = !s1_valid || o_load;
  assign init_done   = (state != B_CLEAR);
  assign pair_start  = (scan_row >= 5'(HALF)) ? 5'd0 : scan_row;
  assign hi_row_full = {1'b0, pair} + 6'(HALF);
  assign lo_addr     = {pair[RW-1:0], col_cnt};
  assign hi_addr     = {hi_row_full[RW-1:0], col_cnt};

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR, B_FILL: begin
        if (last_col && last_row) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          case (head.op)
            CMD_FILL:    state_next = B_FILL;
            CMD_REFRESH: state_next = B_REFRESH;
            default:     state_next = B_IDLE;
          endcase
        end
      end
      B_REFRESH: begin
        if (s1_free && last_col) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {row_cnt, col_cnt};
    mem_wdata = fill_color;
    case (state)
      B_CLEAR, B_FILL: begin
        mem_we = 1'b1;
      end
      B_IDLE: begin
        pop = !empty;
        if (!empty && head.op == CMD_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = {head.row[RW-1:0], head.col[CW-1:0]};
          mem_wdata = head.color;
        end
      end
      B_REFRESH: begin
        issue = s1_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      fill_color <= '0;
      scan_row   <= '0;
      pair       <= '0;
    end else begin
      case (state)
        B_CLEAR, B_FILL: begin
          if (last_col) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
        B_IDLE: begin
          if (pop) begin
            col_cnt <= '0;
            row_cnt <= '0;
            if (head.op == CMD_FILL) begin
              fill_color <= head.color;
            end
            if (head.op == CMD_REFRESH) begin
              pair     <= pair_start;
              scan_row <= pair_start + 5'd1;
            end
          end
        end
        B_REFRESH: begin
          if (issue) begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      lo_data <= mem[lo_addr];
      hi_data <= mem[hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_latch <= last_col;
      s1_addr  <= (pair > 5'(ADDR_MAX)) ? ADDR_MAX : pair[3:0];
    end
    if (o_load) begin
      out_ch.payload.row_address <= s1_addr;
      out_ch.payload.upper_shade <= hi_data;
      out_ch.payload.lower_shade <= lo_data;
      out_ch.payload.latch_now   <= s1_latch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (o_load) begin
        s1_valid <= 1'b0;
      end
      if (o_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule
